/* hdl/rdsgb_pkg.sv */
// ----------------------------------------------------------------------------
// RDS group encoder package
// Shared codes, constants and the block checkword function.
// ----------------------------------------------------------------------------
package rdsgb_pkg;

  localparam int AF_MAX_DEF = 25;

  // Radiotext store: 64 characters kept as 16 rows of four characters.
  localparam int TEXT_ROWS = 16;

  localparam logic [7:0] SPACE_CHAR     = 8'h20;
  localparam logic [7:0] AF_HEADER_BASE = 8'd224;
  localparam logic [3:0] GROUP_CODE_2A  = 4'd2;

  typedef enum logic [1:0] {
    REQ_GROUP = 2'd0,
    REQ_TEXT  = 2'd1,
    REQ_AF    = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    CFG_PROGRAM_ID   = 3'd0,
    CFG_PROGRAM_TYPE = 3'd1,
    CFG_TRAFFIC_PROG = 3'd2,
    CFG_TRAFFIC_ANN  = 3'd3,
    CFG_MUSIC_SPEECH = 3'd4,
    CFG_TEXT_AB      = 3'd5,
    CFG_STATION_NAME = 3'd6,
    CFG_AF_COUNT     = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    POS_A = 2'd0,
    POS_B = 2'd1,
    POS_C = 2'd2,
    POS_D = 2'd3
  } blk_pos_t;

  localparam logic [9:0] BLOCK_OFFSET [4] = '{10'h0FC, 10'h198, 10'h168, 10'h1B4};

  // Remainder of x^(i+10) modulo the generator 0x5B9, one row per info bit.
  localparam logic [9:0] CRC_SYN [16] = '{
    10'h1B9, 10'h372, 10'h35D, 10'h303, 10'h3BF, 10'h2C7, 10'h037, 10'h06E,
    10'h0DC, 10'h1B8, 10'h370, 10'h359, 10'h30B, 10'h3AF, 10'h2E7, 10'h077
  };

  // The CRC is linear, so it is the XOR of the rows selected by the info bits.
  function automatic logic [9:0] crc10(input logic [15:0] info);
    logic [9:0] acc;
    acc = '0;
    for (int i = 0; i < 16; i++) begin
      if (info[i]) begin
        acc = acc ^ CRC_SYN[i];
      end
    end
    return acc;
  endfunction

  // x mod n for x below 2n; any value mod 1 is zero.
  function automatic logic [4:0] wrap_once(input logic [5:0] x, input logic [4:0] n);
    logic [4:0] res;
    if (n <= 5'd1) begin
      res = '0;
    end else if (x >= {1'b0, n}) begin
      res = 5'(x - {1'b0, n});
    end else begin
      res = x[4:0];
    end
    return res;
  endfunction

endpackage

/* hdl/rds_group_block_encoder.sv */
// ----------------------------------------------------------------------------
// RDS group block encoder
// Emits 0A / 0A / 2A groups as four checked blocks; stores RT and AF data.
// ----------------------------------------------------------------------------
// Block A of a group passes from the request through the group stage into
// the output register; blocks B, C and D follow one per cycle while the
// single output register is not stalled. A new request or store write is
// taken once no group is busy, or in the cycle that block D moves out.
// Reset is synchronous and active low; the text and AF stores read as their
// reset values through per-entry valid bits, so no clearing pass is needed.
module rds_group_block_encoder import rdsgb_pkg::*; #(
  parameter int AF_MAX = AF_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] slot, [13:6] data_byte, [15:14] zero
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [25:0] block_word, [27:26] block_pos, [31:28] zero
  output logic        out_tuser,  // [0] group_kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int AF_AW = (AF_MAX > 1) ? $clog2(AF_MAX) : 1;

  // Configuration registers
  logic [15:0] program_id_r;
  logic [4:0]  program_type_r;
  logic        traffic_prog_r;
  logic        traffic_ann_r;
  logic        music_speech_r;
  logic        text_ab_r;
  logic [63:0] station_name_r;
  logic [4:0]  af_count_r;

  // Sequencing state
  logic [1:0]  ps_seg_r, ps_seg_nxt;
  logic [3:0]  rt_seg_r, rt_seg_nxt;
  logic [1:0]  rot_r, rot_nxt;
  logic [4:0]  af_cur_r, af_cur_nxt;

  // Stores
  logic [31:0]       txt_mem [TEXT_ROWS];
  logic [63:0]       txt_vld_r;
  logic [7:0]        af_mem [AF_MAX];
  logic [AF_MAX-1:0] af_vld_r;

  // Group stage
  logic        grp_busy_r;
  logic [1:0]  phase_r;
  logic        grp_kind_r;
  logic [15:0] grp_b_r;
  logic [15:0] grp_ps_r;
  logic        grp_hdr_r;
  logic [4:0]  grp_n_r;
  logic [31:0] txt_rd_r;
  logic [3:0]  txt_v_r;
  logic [7:0]  af_rd0_r, af_rd1_r;
  logic        af_v0_r, af_v1_r;

  // Output register
  logic        out_valid_r;
  logic [25:0] out_word_r;
  logic [1:0]  out_pos_r;
  logic        out_kind_r;
  logic        out_last_r;

  logic [5:0]  in_slot;
  logic [7:0]  in_data;
  logic        in_acc, grp_acc, txt_wr, af_wr;
  logic        kind_2a;
  logic [4:0]  af_n;
  logic [4:0]  af_idx0, af_idx1;
  logic [15:0] b_info;
  logic        move, last_move;
  logic [7:0]  rt_char [4];
  logic [7:0]  af_a0, af_a1;
  logic [15:0] af_pair;
  logic [15:0] info;
  logic [25:0] word;

  assign in_slot = in_tdata[5:0];
  assign in_data = in_tdata[13:6];

  assign move      = grp_busy_r && (!out_valid_r || out_tready);
  assign last_move = move && (phase_r == POS_D);
  assign in_tready = !grp_busy_r || last_move;

  assign in_acc  = in_tvalid && in_tready;
  assign grp_acc = in_acc && (in_tuser == REQ_GROUP);
  assign txt_wr  = in_acc && (in_tuser == REQ_TEXT);
  assign af_wr   = in_acc && (in_tuser == REQ_AF) && (in_slot < 6'(AF_MAX));

  assign kind_2a = (rot_r == 2'd2);
  assign af_n    = (af_count_r > 5'(AF_MAX)) ? 5'(AF_MAX) : af_count_r;

  // The header pair reads entry 0; otherwise two entries from the cursor on.
  assign af_idx0 = (af_cur_r == 5'd0) ? 5'd0 : wrap_once({1'b0, af_cur_r}, af_n);
  assign af_idx1 = wrap_once(6'({1'b0, af_cur_r} + 6'd1), af_n);

  always_comb begin
    if (kind_2a) begin
      b_info = {GROUP_CODE_2A, 1'b0, traffic_prog_r, program_type_r, text_ab_r, rt_seg_r};
    end else begin
      b_info = {4'd0, 1'b0, traffic_prog_r, program_type_r, traffic_ann_r,
                music_speech_r, 1'b0, ps_seg_r};
    end
  end

  always_comb begin
    ps_seg_nxt = ps_seg_r;
    rt_seg_nxt = rt_seg_r;
    rot_nxt    = rot_r;
    af_cur_nxt = af_cur_r;
    if (grp_acc) begin
      rot_nxt = kind_2a ? 2'd0 : 2'(rot_r + 2'd1);
      if (kind_2a) begin
        rt_seg_nxt = 4'(rt_seg_r + 4'd1);
      end else begin
        ps_seg_nxt = 2'(ps_seg_r + 2'd1);
        if (af_n != 5'd0) begin
          af_cur_nxt = (af_cur_r == 5'd0) ? 5'd1
                                          : wrap_once(6'({1'b0, af_cur_r} + 6'd2), af_n);
        end
      end
    end
    // Writing the AF count restarts the AF sequence with its header.
    if (cfg_we && (cfg_index == CFG_AF_COUNT)) begin
      af_cur_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      program_id_r   <= 16'h1234;
      program_type_r <= '0;
      traffic_prog_r <= 1'b0;
      traffic_ann_r  <= 1'b0;
      music_speech_r <= 1'b1;
      text_ab_r      <= 1'b0;
      station_name_r <= {8{SPACE_CHAR}};
      af_count_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROGRAM_ID:   program_id_r   <= cfg_wdata[15:0];
        CFG_PROGRAM_TYPE: program_type_r <= cfg_wdata[4:0];
        CFG_TRAFFIC_PROG: traffic_prog_r <= cfg_wdata[0];
        CFG_TRAFFIC_ANN:  traffic_ann_r  <= cfg_wdata[0];
        CFG_MUSIC_SPEECH: music_speech_r <= cfg_wdata[0];
        CFG_TEXT_AB:      text_ab_r      <= cfg_wdata[0];
        CFG_STATION_NAME: station_name_r <= cfg_wdata;
        CFG_AF_COUNT:     af_count_r     <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_seg_r   <= '0;
      rt_seg_r   <= '0;
      rot_r      <= '0;
      af_cur_r   <= '0;
      txt_vld_r  <= '0;
      af_vld_r   <= '0;
      grp_busy_r <= 1'b0;
      phase_r    <= '0;
    end else begin
      ps_seg_r <= ps_seg_nxt;
      rt_seg_r <= rt_seg_nxt;
      rot_r    <= rot_nxt;
      af_cur_r <= af_cur_nxt;
      if (txt_wr) begin
        txt_vld_r[in_slot] <= 1'b1;
      end
      if (af_wr) begin
        af_vld_r[in_slot[AF_AW-1:0]] <= 1'b1;
      end
      if (grp_acc) begin
        grp_busy_r <= 1'b1;
        phase_r    <= '0;
      end else if (move) begin
        grp_busy_r <= !last_move;
        phase_r    <= 2'(phase_r + 2'd1);
      end
    end
  end

  // Text store: byte-wide writes, one row of four characters per read.
  always_ff @(posedge clk) begin
    if (txt_wr) begin
      txt_mem[in_slot[5:2]][{in_slot[1:0], 3'b000} +: 8] <= in_data;
    end
    if (grp_acc) begin
      txt_rd_r <= txt_mem[rt_seg_r];
      txt_v_r  <= txt_vld_r[{rt_seg_r, 2'b00} +: 4];
    end
  end

  // AF store: one write port, two read ports.
  always_ff @(posedge clk) begin
    if (af_wr) begin
      af_mem[in_slot[AF_AW-1:0]] <= in_data;
    end
    if (grp_acc) begin
      af_rd0_r <= af_mem[af_idx0[AF_AW-1:0]];
      af_rd1_r <= af_mem[af_idx1[AF_AW-1:0]];
      af_v0_r  <= af_vld_r[af_idx0[AF_AW-1:0]];
      af_v1_r  <= af_vld_r[af_idx1[AF_AW-1:0]];
    end
  end

  // Per-group fields captured with the request, before the segments advance.
  always_ff @(posedge clk) begin
    if (grp_acc) begin
      grp_kind_r <= kind_2a;
      grp_b_r    <= b_info;
      grp_ps_r   <= station_name_r[{~ps_seg_r, 4'b0000} +: 16];
      grp_hdr_r  <= (af_cur_r == 5'd0);
      grp_n_r    <= af_n;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rt_char[k] = txt_v_r[k] ? txt_rd_r[8*k +: 8] : SPACE_CHAR;
    end
    af_a0 = af_v0_r ? af_rd0_r : 8'd0;
    af_a1 = af_v1_r ? af_rd1_r : 8'd0;
    if (grp_n_r == 5'd0) begin
      af_pair = '0;
    end else if (grp_hdr_r) begin
      af_pair = {8'(AF_HEADER_BASE + {3'd0, grp_n_r}), af_a0};
    end else begin
      af_pair = {af_a0, af_a1};
    end
  end

  always_comb begin
    case (phase_r)
      POS_A:   info = program_id_r;
      POS_B:   info = grp_b_r;
      POS_C:   info = grp_kind_r ? {rt_char[0], rt_char[1]} : af_pair;
      POS_D:   info = grp_kind_r ? {rt_char[2], rt_char[3]} : grp_ps_r;
      default: info = program_id_r;
    endcase
  end

  rdsgb_block_fmt u_fmt (
    .info (info),
    .pos  (blk_pos_t'(phase_r)),
    .word (word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_word_r <= word;
      out_pos_r  <= phase_r;
      out_kind_r <= grp_kind_r;
      out_last_r <= (phase_r == POS_D);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_pos_r, out_word_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

/* hdl/rdsgb_block_fmt.sv */
// ----------------------------------------------------------------------------
// RDS block formatter
// Builds the 26-bit block: info word, CRC-10 and the offset word of its place.
// ----------------------------------------------------------------------------
module rdsgb_block_fmt import rdsgb_pkg::*; (
  input  logic [15:0] info,
  input  blk_pos_t    pos,
  output logic [25:0] word
);

  logic [9:0] check;

  assign check = crc10(info) ^ BLOCK_OFFSET[pos];
  assign word  = {info, check};

endmodule

/* hdl/rdsgb_checker.sv */
// ----------------------------------------------------------------------------
// RDS group encoder port checker
// Watches the output stream for block ordering and framing.
// ----------------------------------------------------------------------------
module rdsgb_checker import rdsgb_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,  // [25:0] block_word, [27:26] block_pos, [31:28] zero
  input logic        out_tuser,  // [0] group_kind
  input logic        out_tlast
);

  // A stalled transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("output changed while stalled");

  // tlast marks block D and nothing else.
  a_last_is_d: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[27:26] == POS_D)))
    else $error("tlast does not match block position");

  // Blocks of one group follow in order and keep the group kind.
  a_block_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) ##1 out_tvalid |->
      (out_tdata[27:26] == 2'($past(out_tdata[27:26]) + 2'd1))
      && (out_tuser == $past(out_tuser)))
    else $error("block out of order within a group");

  // A new group after a block D always opens with block A.
  a_group_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) ##1 out_tvalid |->
      (out_tdata[27:26] == POS_A))
    else $error("group does not start with block A");

endmodule

bind rds_group_block_encoder rdsgb_checker u_rdsgb_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RDS group block encoder testbench
// Drives group requests and store writes through the input stream, predicts
// every 26-bit block with a local model of the 0A/0A/2A rotation and checks
// the output stream in order, under several register settings and stall mixes.
// ----------------------------------------------------------------------------
module tb import rdsgb_pkg::*; ();

  localparam int                 AF_LIMIT    = 25;
  localparam logic [7:0]         AF_HDR      = 8'd224;
  localparam logic [3:0]         GROUP_2A    = 4'd2;
  localparam logic [1:0]         REQ_UNKNOWN = 2'd3;
  localparam logic [10:0]        CRC_GEN     = 11'h5B9;
  localparam logic [3:0][9:0]    OFFSET_WORD = {10'h1B4, 10'h168, 10'h198, 10'h0FC};
  localparam int                 STALL_LIMIT = 2000;
  localparam int                 HOLD_CYCLES = 300;
  localparam int                 SETTLE      = 8;
  localparam int                 PER_PHASE   = 32;

  typedef struct packed {
    logic [25:0] word;
    logic [1:0]  pos;
    logic        kind;
    logic        last;
  } block_exp_t;

  typedef struct packed {
    logic [1:0]  req;
    logic [5:0]  slot;
    logic [7:0]  data;
    logic        typed;
    logic [63:0] info;   // blocks A to D, A in the top 16 bits
  } stim_row_t;

  localparam int DIR_ROWS = 20;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{REQ_GROUP,   6'd0,  8'h00, 1'b1, 64'h1234_0008_0000_2020},
    '{REQ_GROUP,   6'd0,  8'h00, 1'b1, 64'h1234_0009_0000_2020},
    '{REQ_GROUP,   6'd0,  8'h00, 1'b1, 64'h1234_2000_2020_2020},
    '{REQ_TEXT,    6'd0,  8'hFF, 1'b0, 64'h0},
    '{REQ_TEXT,    6'd63, 8'h00, 1'b0, 64'h0},
    '{REQ_TEXT,    6'd1,  8'h41, 1'b0, 64'h0},
    '{REQ_TEXT,    6'd4,  8'h7E, 1'b0, 64'h0},
    '{REQ_TEXT,    6'd5,  8'h80, 1'b0, 64'h0},
    '{REQ_AF,      6'd0,  8'h01, 1'b0, 64'h0},
    '{REQ_AF,      6'd24, 8'hCC, 1'b0, 64'h0},
    '{REQ_AF,      6'd25, 8'h55, 1'b0, 64'h0},
    '{REQ_AF,      6'd63, 8'hFF, 1'b0, 64'h0},
    '{REQ_UNKNOWN, 6'd63, 8'hFF, 1'b0, 64'h0},
    '{REQ_UNKNOWN, 6'd0,  8'h00, 1'b0, 64'h0},
    '{REQ_GROUP,   6'd0,  8'h00, 1'b1, 64'h1234_000A_0000_2020},
    '{REQ_GROUP,   6'd0,  8'h00, 1'b1, 64'h1234_000B_0000_2020},
    '{REQ_GROUP,   6'd0,  8'h00, 1'b1, 64'h1234_2001_7E80_2020},
    '{REQ_GROUP,   6'd0,  8'h00, 1'b1, 64'h1234_0008_0000_2020},
    '{REQ_GROUP,   6'd21, 8'h5A, 1'b0, 64'h0},
    '{REQ_GROUP,   6'd42, 8'hA5, 1'b0, 64'h0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [5:0] slot, [13:6] data_byte, [15:14] zero
  logic [1:0]  in_tuser = '0;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [25:0] block_word, [27:26] block_pos, [31:28] zero
  logic        out_tuser;       // [0] group_kind
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  rds_group_block_encoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Local copy of the encoder registers and state.
  logic [15:0] cfg_pi;
  logic [4:0]  cfg_pty;
  logic        cfg_tp, cfg_ta, cfg_ms, cfg_ab;
  logic [63:0] cfg_ps_name;
  logic [4:0]  cfg_af_cnt;
  logic [7:0]  text_mem [64];
  logic [7:0]  af_mem [AF_LIMIT];
  logic [1:0]  ps_seg;
  logic [3:0]  rt_seg;
  logic [1:0]  rotation;
  logic [4:0]  af_cur;

  block_exp_t  block_q [$];
  logic [15:0] last_out_info [4];

  int err_count;
  int stall_cycles;
  int snd_idle_pct;
  int rcv_idle_pct;
  int hold_left;
  int hold_req;
  int hold_seen;
  int groups_sent, text_writes, af_writes, ignored_items, blocks_checked;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR at %0t: %s: got %h, want %h", $time, what, got, want);
    err_count++;
  endtask

  function automatic logic [9:0] block_check(logic [15:0] info);
    logic [25:0] r;
    r = {info, 10'b0};
    for (int b = 25; b >= 10; b--) begin
      if (r[b]) begin
        r = r ^ (26'(CRC_GEN) << (b - 10));
      end
    end
    return r[9:0];
  endfunction

  task automatic push_block(int pos, logic [15:0] info, logic kind);
    block_exp_t e;
    e.word = {info, block_check(info) ^ OFFSET_WORD[pos]};
    e.pos  = 2'(pos);
    e.kind = kind;
    e.last = (pos == POS_D);
    block_q.push_back(e);
  endtask

  // The first pair after a cursor reset is the count header with the first code.
  function automatic logic [15:0] next_af_pair();
    int n;
    logic [7:0] a1, a2;
    n = (cfg_af_cnt > AF_LIMIT) ? AF_LIMIT : int'(cfg_af_cnt);
    if (n == 0) return 16'h0000;
    if (af_cur == 0) begin
      a1 = AF_HDR + 8'(n);
      a2 = af_mem[0];
      af_cur = 5'd1;
    end else begin
      a1 = af_mem[af_cur % n];
      a2 = af_mem[(af_cur + 1) % n];
      af_cur = 5'((af_cur + 2) % n);
    end
    return {a1, a2};
  endfunction

  task automatic encode_request(logic [1:0] req, logic [5:0] slot, logic [7:0] data);
    logic [5:0] i0;
    case (req)
      REQ_TEXT: begin
        text_mem[slot] = data;
        text_writes++;
      end
      REQ_AF: begin
        if (slot < AF_LIMIT) begin
          af_mem[slot] = data;
          af_writes++;
        end else begin
          ignored_items++;
        end
      end
      REQ_GROUP: begin
        push_block(POS_A, cfg_pi, rotation == 2'd2);
        if (rotation == 2'd2) begin
          i0 = {rt_seg, 2'b00};
          push_block(POS_B, {GROUP_2A, 1'b0, cfg_tp, cfg_pty, cfg_ab, rt_seg}, 1'b1);
          push_block(POS_C, {text_mem[i0], text_mem[i0 + 6'd1]}, 1'b1);
          push_block(POS_D, {text_mem[i0 + 6'd2], text_mem[i0 + 6'd3]}, 1'b1);
          rt_seg = rt_seg + 4'd1;
        end else begin
          push_block(POS_B, {5'b0, cfg_tp, cfg_pty, cfg_ta, cfg_ms, 1'b0, ps_seg}, 1'b0);
          push_block(POS_C, next_af_pair(), 1'b0);
          push_block(POS_D, cfg_ps_name[63 - 16 * ps_seg -: 16], 1'b0);
          ps_seg = ps_seg + 2'd1;
        end
        rotation = (rotation == 2'd2) ? 2'd0 : rotation + 2'd1;
        groups_sent++;
      end
      default: ignored_items++;
    endcase
  endtask

  // Both handshakes are sampled here; inputs only move at the falling edge.
  always @(posedge clk) begin
    block_exp_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (block_q.size() == 0) begin
          report_mismatch("block with nothing expected", 64'(out_tdata), 64'h0);
        end else begin
          e = block_q.pop_front();
          if (out_tdata[25:0] !== e.word) begin
            report_mismatch("block_word", 64'(out_tdata[25:0]), 64'(e.word));
          end
          if (out_tdata[27:26] !== e.pos) begin
            report_mismatch("block_pos", 64'(out_tdata[27:26]), 64'(e.pos));
          end
          if (out_tuser !== e.kind) begin
            report_mismatch("group_kind", 64'(out_tuser), 64'(e.kind));
          end
          if (out_tlast !== e.last) begin
            report_mismatch("last_block", 64'(out_tlast), 64'(e.last));
          end
        end
        last_out_info[out_tdata[27:26]] = out_tdata[25:10];
        blocks_checked++;
      end
      if (in_tvalid && in_tready) begin
        encode_request(in_tuser, in_tdata[5:0], in_tdata[13:6]);
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_left = HOLD_CYCLES;
      hold_seen = hold_req;
    end
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Valid stays high between back-to-back transactions; it drops only on idle.
  task automatic send_item(logic [1:0] req, logic [5:0] slot, logic [7:0] data);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = {2'b00, data, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (block_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_PROGRAM_ID:   cfg_pi = val[15:0];
      CFG_PROGRAM_TYPE: cfg_pty = val[4:0];
      CFG_TRAFFIC_PROG: cfg_tp = val[0];
      CFG_TRAFFIC_ANN:  cfg_ta = val[0];
      CFG_MUSIC_SPEECH: cfg_ms = val[0];
      CFG_TEXT_AB:      cfg_ab = val[0];
      CFG_STATION_NAME: cfg_ps_name = val;
      CFG_AF_COUNT: begin
        cfg_af_cnt = val[4:0];
        af_cur = '0;
      end
      default: ;
    endcase
  endtask

  initial begin
    // AF count per phase; a negative entry keeps the random draw.
    int af_plan [7];
    int counted, pick;
    logic [63:0] val;
    logic [1:0]  req;
    logic [5:0]  slot;
    logic [7:0]  data;
    af_plan = '{0, 25, 1, 31, -1, 2, -1};

    cfg_pi = 16'h1234;
    cfg_pty = '0;
    cfg_tp = 1'b0;
    cfg_ta = 1'b0;
    cfg_ms = 1'b1;
    cfg_ab = 1'b0;
    cfg_ps_name = {8{8'h20}};
    cfg_af_cnt = '0;
    foreach (text_mem[i]) text_mem[i] = 8'h20;
    foreach (af_mem[i]) af_mem[i] = 8'h00;
    ps_seg = '0;
    rt_seg = '0;
    rotation = '0;
    af_cur = '0;
    snd_idle_pct = 29;
    rcv_idle_pct = 63;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(DIRECTED[i].req, DIRECTED[i].slot, DIRECTED[i].data);
      if (DIRECTED[i].typed) begin
        wait_results();
        for (int k = 0; k < 4; k++) begin
          if (last_out_info[k] !== DIRECTED[i].info[63 - 16 * k -: 16]) begin
            report_mismatch($sformatf("row %0d block %0d info", i, k),
                            64'(last_out_info[k]),
                            64'(DIRECTED[i].info[63 - 16 * k -: 16]));
          end
        end
      end
    end

    for (int ph = 1; ph <= 6; ph++) begin
      wait_results();
      repeat (SETTLE) @(negedge clk);
      // Outside the AF count, phase one writes all ones, phase two all zeros.
      for (int r = 0; r < 8; r++) begin
        val = {$urandom(), $urandom()};
        if (ph == 1) val = '1;
        if (ph == 2) val = '0;
        if (r == CFG_AF_COUNT && af_plan[ph] >= 0) val = 64'(af_plan[ph]);
        write_reg(cfg_idx_t'(r), val);
      end
      if (ph == 3) begin
        snd_idle_pct = 63;
        rcv_idle_pct = 29;
      end else if (ph == 5) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      if (ph == 2) hold_req++;

      counted = 0;
      while (counted < PER_PHASE) begin
        pick = $urandom_range(0, 99);
        slot = 6'($urandom_range(0, 63));
        data = 8'($urandom_range(0, 255));
        if (pick < 50) begin
          req = REQ_GROUP;
        end else if (pick < 72) begin
          req = REQ_TEXT;
        end else if (pick < 92) begin
          req = REQ_AF;
          if ($urandom_range(0, 99) < 85) slot = 6'($urandom_range(0, AF_LIMIT - 1));
        end else begin
          req = REQ_UNKNOWN;
        end
        send_item(req, slot, data);
        if (req != REQ_UNKNOWN && !(req == REQ_AF && slot >= AF_LIMIT)) counted++;
      end
    end

    wait_results();
    repeat (SETTLE) @(negedge clk);
    if (block_q.size() != 0) begin
      report_mismatch("blocks still expected", 64'(block_q.size()), 64'h0);
    end

    $display("Covered %0d groups (%0d blocks), %0d text writes, %0d AF writes,",
             groups_sent, blocks_checked, text_writes, af_writes);
    $display("%0d ignored requests, reset settings plus six register phases.",
             ignored_items);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
